// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: hdl/bf_pkg.sv
// Shared types and constants for the shortest-path unit.
// No dependencies; used by the controller, datapath, top level and checker.
package bf_pkg;

   // fixed field widths
   localparam int VERTEX_W = 6;
   localparam int VCOUNT_W = 7;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;

   // parameter defaults
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
   localparam logic [DIST_W-1:0]   DIST_MAX     = 32'h7FFF_FFFF;
   localparam logic [DIST_W-1:0]   DIST_MIN     = 32'h8000_0000;

   // one edge item
   typedef struct packed {
      logic [VERTEX_W-1:0]        from_vertex;
      logic [VERTEX_W-1:0]        to_vertex;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last_edge;
   } bf_req_type;

   // one result item
   typedef struct packed {
      logic                     no_negative_cycle;
      logic [VERTEX_W-1:0]      vertex;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic                     last;
   } bf_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic store_edge;
      logic init;
      logic edge_rd;
      logic dist_rd;
      logic relax;
      logic out_rd;
      logic out_load;
      logic out_next;
      logic finish;
   } bf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_edge_idx;
      logic check_pass;
      logic out_last;
   } bf_stat_type;

endpackage

// File: hdl/bf_ctrl.sv
// Sequencer for load, relaxation passes and result delivery.
// Depends on bf_pkg; drives commands into bf_dpath and reads its status.
module bf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_edge,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bf_pkg::bf_stat_type stat,
   output bf_pkg::bf_cmd_type  cmd
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_RELAX = 3'd4;
   localparam logic [2:0] S_ORD   = 3'd5;
   localparam logic [2:0] S_OVAL  = 3'd6;
   localparam logic [2:0] S_OHOLD = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // handshake decode straight from the state register
   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = (state_ff == S_OHOLD);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            cmd.store_edge = req_valid;
            if (req_valid && req_last_edge) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.edge_rd = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.dist_rd = 1'b1;
            state_in    = S_RELAX;
         end
         S_RELAX: begin
            cmd.relax = 1'b1;
            if (stat.last_edge_idx && stat.check_pass) begin
               state_in = S_ORD;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_ORD: begin
            cmd.out_rd = 1'b1;
            state_in   = S_OVAL;
         end
         S_OVAL: begin
            cmd.out_load = 1'b1;
            state_in     = S_OHOLD;
         end
         S_OHOLD: begin
            if (!rsp_stall) begin
               if (stat.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/bf_dpath.sv
// Edge store, distance memory, relax arithmetic and result register.
// Depends on bf_pkg; steered by commands from bf_ctrl.
module bf_dpath #(
   parameter int MAX_VERTICES = bf_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bf_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = bf_pkg::WEIGHT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bf_pkg::bf_req_type                 req_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bf_pkg::VCOUNT_W-1:0]        csr_data,
   input  bf_pkg::bf_cmd_type                 cmd,
   output bf_pkg::bf_stat_type                stat,
   output bf_pkg::bf_rsp_type                 rsp_data
);

   localparam int VA_W = $clog2(MAX_VERTICES);
   localparam int NV_W = $clog2(MAX_VERTICES + 1);
   localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int VW   = bf_pkg::VERTEX_W;
   localparam int E_W  = 2 * VW + WEIGHT_BITS;
   localparam int DW   = bf_pkg::DIST_W;

   // vertex count register
   logic [bf_pkg::VCOUNT_W-1:0] vcount_ff;
   logic [NV_W-1:0]             nv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= bf_pkg::VCOUNT_RESET;
      end else if (csr_valid) begin
         vcount_ff <= csr_data;
      end
   end

   // clamp to 1..MAX_VERTICES
   always_comb begin
      priority if (vcount_ff == '0) begin
         nv = NV_W'(1);
      end else if (vcount_ff > bf_pkg::VCOUNT_W'(MAX_VERTICES)) begin
         nv = NV_W'(MAX_VERTICES);
      end else begin
         nv = vcount_ff[NV_W-1:0];
      end
   end

   // edge store, appended one item at a time
   logic [E_W-1:0]         edge_mem [MAX_EDGES];
   logic [EC_W-1:0]        ecount_ff;
   logic [DW-1:0]          wfull;
   logic [E_W-1:0]         edge_q_ff;

   assign wfull = DW'(req_data.weight);

   always_ff @(posedge clock) begin
      if (cmd.store_edge && (ecount_ff < EC_W'(MAX_EDGES))) begin
         edge_mem[ecount_ff[EA_W-1:0]] <= {req_data.from_vertex, req_data.to_vertex,
                                           wfull[WEIGHT_BITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecount_ff <= '0;
      end else if (cmd.finish) begin
         ecount_ff <= '0;
      end else if (cmd.store_edge && (ecount_ff < EC_W'(MAX_EDGES))) begin
         ecount_ff <= ecount_ff + 1'b1;
      end
   end

   // pass and edge counters
   logic [EA_W-1:0] eidx_ff;
   logic [NV_W-1:0] pass_ff;
   logic [VA_W-1:0] oidx_ff;
   logic            neg_ff;
   logic            hit;

   assign stat.last_edge_idx = ((EC_W'(eidx_ff) + 1'b1) == ecount_ff);
   assign stat.check_pass    = (pass_ff == nv);
   assign stat.out_last      = neg_ff || ((NV_W'(oidx_ff) + 1'b1) == nv);

   always_ff @(posedge clock) begin
      if (reset) begin
         eidx_ff <= '0;
         pass_ff <= '0;
         oidx_ff <= '0;
         neg_ff  <= 1'b0;
      end else if (cmd.init) begin
         eidx_ff <= '0;
         pass_ff <= '0;
         oidx_ff <= '0;
         neg_ff  <= 1'b0;
      end else begin
         if (cmd.relax) begin
            if (stat.last_edge_idx) begin
               eidx_ff <= '0;
               pass_ff <= pass_ff + 1'b1;
            end else begin
               eidx_ff <= eidx_ff + 1'b1;
            end
            if (hit && stat.check_pass) begin
               neg_ff <= 1'b1;
            end
         end
         if (cmd.out_next) begin
            oidx_ff <= oidx_ff + 1'b1;
         end
      end
   end

   // fetched edge fields
   logic [VW-1:0]          src;
   logic [VW-1:0]          dst;
   logic [WEIGHT_BITS-1:0] wraw;

   assign src  = edge_q_ff[E_W-1 -: VW];
   assign dst  = edge_q_ff[E_W-VW-1 -: VW];
   assign wraw = edge_q_ff[WEIGHT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.edge_rd) begin
         edge_q_ff <= edge_mem[eidx_ff];
      end
   end

   // distance memory with valid bits in flops
   logic [DW-1:0]           dist_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] vld_ff;
   logic [VA_W-1:0]         addr_a;
   logic [DW-1:0]           da_ff;
   logic [DW-1:0]           db_ff;
   logic                    va_ff;
   logic                    vb_ff;
   logic                    inrange_ff;
   logic [DW-1:0]           nd;

   assign addr_a = cmd.out_rd ? oidx_ff : src[VA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.dist_rd || cmd.out_rd) begin
         da_ff <= dist_mem[addr_a];
         va_ff <= vld_ff[addr_a];
      end
      if (cmd.dist_rd) begin
         db_ff      <= dist_mem[dst[VA_W-1:0]];
         vb_ff      <= vld_ff[dst[VA_W-1:0]];
         inrange_ff <= (NV_W'(src) < nv) && (NV_W'(dst) < nv) &&
                       ({1'b0, src} < (VW + 1)'(nv)) && ({1'b0, dst} < (VW + 1)'(nv));
      end
   end

   // write port: source seed at init, relaxed distance otherwise
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         dist_mem[0] <= '0;
      end else if (cmd.relax && hit && !stat.check_pass) begin
         dist_mem[dst[VA_W-1:0]] <= nd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.init) begin
         vld_ff <= MAX_VERTICES'(1);
      end else if (cmd.relax && hit && !stat.check_pass) begin
         vld_ff[dst[VA_W-1:0]] <= 1'b1;
      end
   end

   // saturating add and compare
   logic [DW:0] sum;
   logic [DW:0] wsx;

   assign wsx = {{(DW + 1 - WEIGHT_BITS){wraw[WEIGHT_BITS-1]}}, wraw};
   assign sum = {da_ff[DW-1], da_ff} + wsx;

   always_comb begin
      if (sum[DW] != sum[DW-1]) begin
         nd = sum[DW] ? bf_pkg::DIST_MIN : bf_pkg::DIST_MAX;
      end else begin
         nd = sum[DW-1:0];
      end
   end

   assign hit = inrange_ff && va_ff && (!vb_ff || ($signed(nd) < $signed(db_ff)));

   // result register
   bf_pkg::bf_rsp_type rsp_ff;

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (neg_ff) begin
            rsp_ff <= '{no_negative_cycle: 1'b0, vertex: '0, distance: '0,
                        reachable: 1'b0, last: 1'b1};
         end else begin
            rsp_ff.no_negative_cycle <= 1'b1;
            rsp_ff.vertex            <= VW'(oidx_ff);
            rsp_ff.distance          <= va_ff ? da_ff : '0;
            rsp_ff.reachable         <= va_ff;
            rsp_ff.last              <= stat.out_last;
         end
      end
   end

endmodule

// File: hdl/bellman_ford_shortest_paths_unit.sv
// Load: one edge per cycle. After the last edge: a setup step, then for each stored
// edge in each of (clamped vertex_count + 1) passes, the edge-fetch, distance-read
// and relax/write steps on the single distance memory.
// Results: each item is read, loaded and then held under back-pressure; the next is
// read only after it is taken. Next graph loads after the last. Reset: control state
// and edge count cleared, vertex_count = 64; edge store contents are not cleared.
module bellman_ford_shortest_paths_unit #(
   parameter int MAX_VERTICES = bf_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bf_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = bf_pkg::WEIGHT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bf_pkg::bf_req_type          req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bf_pkg::bf_rsp_type          rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bf_pkg::VCOUNT_W-1:0] csr_data
);

   bf_pkg::bf_cmd_type  cmd;
   bf_pkg::bf_stat_type stat;

   bf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_edge (req_data.last_edge),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   bf_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/bf_checker.sv
// Port-level checks for the shortest-path unit, bound to the top level.
// Depends on bf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input bf_pkg::bf_req_type          req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input bf_pkg::bf_rsp_type          rsp_data
);

   logic neg_rsp;
   logic last_in;
   logic last_out;

   // handshake shorthands
   assign neg_rsp  = rsp_valid && !rsp_data.no_negative_cycle;
   assign last_in  = req_valid && !req_stall && req_data.last_edge;
   assign last_out = rsp_valid && !rsp_stall && rsp_data.last;

   // no result is offered while edges are being taken
   `BF_ASSERT_NOW(a_load_no_rsp, clock, reset, !req_stall, !rsp_valid)

   // a stalled result item holds
   `BF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // the negative-cycle report is a single final item
   `BF_ASSERT_NOW(a_neg_last, clock, reset, neg_rsp, rsp_data.last && !rsp_data.reachable)

   // last edge starts the run, last result ends it
   `BF_ASSERT_NEXT(a_run_start, clock, reset, last_in, req_stall && !rsp_valid)
   `BF_ASSERT_NEXT(a_run_end, clock, reset, last_out, !rsp_valid && !req_stall)

endmodule

bind bellman_ford_shortest_paths_unit bf_checker u_checker (.*);
